// ----- hdl/uvcfa_pkg.sv -----
// ----------------------------------------------------------------------------
// uvcfa_pkg: shared types and constants of the video payload frame assembler
// Header flag masks, header length limits, header room codes, the request and
// result records, and the record that carries the results of one request.
// ----------------------------------------------------------------------------
`default_nettype none

package uvcfa_pkg;

    localparam logic [7:0] FLAG_FID = 8'h01;
    localparam logic [7:0] FLAG_EOF = 8'h02;
    localparam logic [7:0] FLAG_PTS = 8'h04;
    localparam logic [7:0] FLAG_SCR = 8'h08;
    localparam logic [7:0] FLAG_ERR = 8'h40;

    localparam logic [7:0] HDR_MIN_LEN  = 8'd2;
    localparam logic [7:0] PTS_HDR_LEN  = 8'd6;
    localparam logic [7:0] FULL_HDR_LEN = 8'd12;

    localparam logic [1:0] ROOM_NONE  = 2'd0;
    localparam logic [1:0] ROOM_FLAGS = 2'd1;

    localparam int OUT_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [63:0] timestamp_ns;
        logic        packet_error;
        logic [15:0] packet_length;
        logic [1:0]  header_room;
        logic [7:0]  header_length;
        logic [7:0]  header_flags;
        logic [31:0] pts_field;
        logic [31:0] stc_field;
        logic [15:0] sof_field;
    } in_item_t;

    typedef struct packed {
        logic [31:0] frame_bytes;
        logic [31:0] frame_packets;
        logic [31:0] frame_error_packets;
        logic [31:0] frame_duration;
        logic [31:0] frame_interval;
        logic [31:0] frame_pts;
        logic [31:0] frame_stc;
        logic [15:0] frame_sof;
        logic        frame_errored;
        logic        frame_eof;
        logic        frame_fid;
        logic        last_of_item;
    } result_t;

    // Up to two closed frames per request: a FID toggle close, then an EOF close.
    typedef struct packed {
        logic    valid_a;
        logic    valid_b;
        result_t res_a;
        result_t res_b;
    } push_t;

endpackage

`default_nettype wire

// ----- hdl/uvcfa_core.sv -----
// ----------------------------------------------------------------------------
// uvcfa_core: request register, frame state and close logic
// Holds one request, updates the frame state in a single pass when enabled
// and the result queue has room for two entries, and hands closed frames on.
// ----------------------------------------------------------------------------
`default_nettype none

module uvcfa_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire uvcfa_pkg::in_item_t in_item,
    input  wire logic              push_room,
    output uvcfa_pkg::push_t       push
);
    import uvcfa_pkg::*;

    logic        in_vld_reg;
    in_item_t    in_reg;
    logic        frames_enable_reg;

    logic [31:0] fst_reg, fst_next;
    logic [31:0] lct_lo_reg, lct_lo_next;
    logic        lct_nz_reg, lct_nz_next;
    logic [31:0] bc_reg, bc_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] epc_reg, epc_next;
    logic [31:0] pts_reg, pts_next;
    logic [31:0] stc_reg, stc_next;
    logic [15:0] sof_reg, sof_next;
    logic        fid_reg, fid_next;
    logic        fid_known_reg, fid_known_next;
    logic        es_reg, es_next;
    logic        open_reg, open_next;

    logic        advance;
    logic        do_step;
    logic        hdr_ok;
    logic        toggle;
    logic        eof;

    assign advance  = in_vld_reg && push_room;
    assign do_step  = advance && frames_enable_reg;
    assign in_ready = !in_vld_reg || push_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_ready) begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_reg <= in_item;
        end
    end

    always_comb begin
        logic [31:0] now_lo;
        logic [31:0] epc1;
        logic        es1;
        logic        full_hdr;
        logic [31:0] pts_in;
        logic [31:0] stc_in;
        logic [15:0] sof_in;
        logic        fid;
        logic        open_new;
        logic [31:0] bc0, pc0, epc0, pts0, stc0, fst0, lct0;
        logic [15:0] sof0;
        logic        es0, lctnz0, fid0;
        logic [31:0] bc1, pc1, pts1, stc1;
        logic [15:0] sof1;
        logic        es2;
        logic        now_nz;

        now_lo   = in_reg.timestamp_ns[31:0];
        now_nz   = in_reg.timestamp_ns != 64'd0;
        epc1     = epc_reg + {31'd0, in_reg.packet_error};
        es1      = es_reg | in_reg.packet_error;
        hdr_ok   = (in_reg.packet_length != 16'd0) && (in_reg.header_room != ROOM_NONE)
                   && (in_reg.header_length >= HDR_MIN_LEN)
                   && ({8'd0, in_reg.header_length} <= in_reg.packet_length);
        // Room code 3 is taken as a full header.
        full_hdr = in_reg.header_room != ROOM_FLAGS;
        pts_in   = full_hdr ? in_reg.pts_field : 32'd0;
        stc_in   = full_hdr ? in_reg.stc_field : 32'd0;
        sof_in   = full_hdr ? in_reg.sof_field : 16'd0;
        fid      = (in_reg.header_flags & FLAG_FID) != 8'd0;
        eof      = (in_reg.header_flags & FLAG_EOF) != 8'd0;
        open_new = !open_reg;
        toggle   = open_reg && fid_known_reg && (fid != fid_reg);

        push.res_a.frame_bytes         = bc_reg;
        push.res_a.frame_packets       = pc_reg;
        push.res_a.frame_error_packets = epc1;
        push.res_a.frame_duration      = now_lo - fst_reg;
        push.res_a.frame_interval      = lct_nz_reg ? now_lo - lct_lo_reg : 32'd0;
        push.res_a.frame_pts           = pts_reg;
        push.res_a.frame_stc           = stc_reg;
        push.res_a.frame_sof           = sof_reg;
        push.res_a.frame_errored       = 1'b1;
        push.res_a.frame_eof           = 1'b0;
        push.res_a.frame_fid           = fid_reg;
        push.res_a.last_of_item        = !eof;

        // A toggle close empties the frame before this packet is counted.
        bc0    = toggle ? 32'd0 : bc_reg;
        pc0    = toggle ? 32'd0 : pc_reg;
        epc0   = toggle ? 32'd0 : epc1;
        es0    = toggle ? 1'b0 : es1;
        pts0   = toggle ? 32'd0 : pts_reg;
        stc0   = toggle ? 32'd0 : stc_reg;
        sof0   = toggle ? 16'd0 : sof_reg;
        lct0   = toggle ? now_lo : lct_lo_reg;
        lctnz0 = toggle ? now_nz : lct_nz_reg;
        fst0   = (toggle || open_new) ? now_lo : fst_reg;
        fid0   = (toggle || open_new) ? fid : fid_reg;

        bc1  = bc0 + {16'd0, in_reg.packet_length - {8'd0, in_reg.header_length}};
        pc1  = pc0 + 32'd1;
        es2  = es0 || ((in_reg.header_flags & FLAG_ERR) != 8'd0);
        pts1 = ((in_reg.header_flags & FLAG_PTS) != 8'd0 && in_reg.header_length >= PTS_HDR_LEN)
               ? pts_in : pts0;
        if ((in_reg.header_flags & FLAG_PTS) != 8'd0 && (in_reg.header_flags & FLAG_SCR) != 8'd0
            && in_reg.header_length >= FULL_HDR_LEN) begin
            stc1 = stc_in;
            sof1 = sof_in;
        end else begin
            stc1 = stc0;
            sof1 = sof0;
        end

        push.res_b.frame_bytes         = bc1;
        push.res_b.frame_packets       = pc1;
        push.res_b.frame_error_packets = epc0;
        push.res_b.frame_duration      = now_lo - fst0;
        push.res_b.frame_interval      = lctnz0 ? now_lo - lct0 : 32'd0;
        push.res_b.frame_pts           = pts1;
        push.res_b.frame_stc           = stc1;
        push.res_b.frame_sof           = sof1;
        push.res_b.frame_errored       = es2;
        push.res_b.frame_eof           = 1'b1;
        push.res_b.frame_fid           = fid0;
        push.res_b.last_of_item        = 1'b1;

        push.valid_a = do_step && hdr_ok && toggle;
        push.valid_b = do_step && hdr_ok && eof;

        fst_next       = fst_reg;
        lct_lo_next    = lct_lo_reg;
        lct_nz_next    = lct_nz_reg;
        bc_next        = bc_reg;
        pc_next        = pc_reg;
        epc_next       = epc1;
        pts_next       = pts_reg;
        stc_next       = stc_reg;
        sof_next       = sof_reg;
        fid_next       = fid_reg;
        fid_known_next = fid_known_reg;
        es_next        = es1;
        open_next      = open_reg;
        if (hdr_ok) begin
            fst_next       = fst0;
            fid_next       = fid0;
            fid_known_next = 1'b1;
            if (eof) begin
                lct_lo_next = now_lo;
                lct_nz_next = now_nz;
                bc_next     = 32'd0;
                pc_next     = 32'd0;
                epc_next    = 32'd0;
                pts_next    = 32'd0;
                stc_next    = 32'd0;
                sof_next    = 16'd0;
                es_next     = 1'b0;
                open_next   = 1'b0;
            end else begin
                lct_lo_next = lct0;
                lct_nz_next = lctnz0;
                bc_next     = bc1;
                pc_next     = pc1;
                epc_next    = epc0;
                pts_next    = pts1;
                stc_next    = stc1;
                sof_next    = sof1;
                es_next     = es2;
                open_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_enable_reg <= 1'b1;
            fst_reg           <= 32'd0;
            lct_lo_reg        <= 32'd0;
            lct_nz_reg        <= 1'b0;
            bc_reg            <= 32'd0;
            pc_reg            <= 32'd0;
            epc_reg           <= 32'd0;
            pts_reg           <= 32'd0;
            stc_reg           <= 32'd0;
            sof_reg           <= 16'd0;
            fid_reg           <= 1'b0;
            fid_known_reg     <= 1'b0;
            es_reg            <= 1'b0;
            open_reg          <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                frames_enable_reg <= cfg_wr_data;
            end
            if (do_step) begin
                fst_reg       <= fst_next;
                lct_lo_reg    <= lct_lo_next;
                lct_nz_reg    <= lct_nz_next;
                bc_reg        <= bc_next;
                pc_reg        <= pc_next;
                epc_reg       <= epc_next;
                pts_reg       <= pts_next;
                stc_reg       <= stc_next;
                sof_reg       <= sof_next;
                fid_reg       <= fid_next;
                fid_known_reg <= fid_known_next;
                es_reg        <= es_next;
                open_reg      <= open_next;
            end
        end
    end

    a_open_has_fid: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg |-> fid_known_reg)
        else $error("frame open without a known FID");

    a_toggle_needs_open: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid_a |-> open_reg && (push.res_a.frame_fid != push.res_b.frame_fid))
        else $error("toggle close without an open frame of the other FID");

    a_eof_close_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid_b |=> !open_reg && bc_reg == 32'd0 && pc_reg == 32'd0)
        else $error("EOF close left the frame open");

    a_disabled_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !frames_enable_reg |-> !push.valid_a && !push.valid_b)
        else $error("result produced while frame reconstruction is off");

endmodule

`default_nettype wire

// ----- hdl/uvcfa_out_fifo.sv -----
// ----------------------------------------------------------------------------
// uvcfa_out_fifo: result queue
// Takes up to two closed frames per cycle in order; delivers one per cycle on
// the result channel while out_ready is high. Room means two free entries.
// ----------------------------------------------------------------------------
`default_nettype none

module uvcfa_out_fifo #(
    parameter int DEPTH = uvcfa_pkg::OUT_FIFO_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire uvcfa_pkg::push_t  push,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output uvcfa_pkg::result_t     out_res
);
    import uvcfa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_1;
    logic               pop;
    logic               push_any;
    logic               push_two;
    result_t            first_res;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign pop       = out_valid && out_ready;
    assign push_any  = push.valid_a || push.valid_b;
    assign push_two  = push.valid_a && push.valid_b;
    assign first_res = push.valid_a ? push.res_a : push.res_b;
    assign wr_ptr_1  = ptr_inc(wr_ptr_reg);
    assign out_valid = count_reg != '0;
    assign out_res   = entry_reg[rd_ptr_reg];
    assign room      = count_reg <= CNT_W'(DEPTH - 2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push_two) begin
            wr_ptr_next = ptr_inc(wr_ptr_1);
        end else if (push_any) begin
            wr_ptr_next = wr_ptr_1;
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'({push_two, push_any && !push_two})
                      - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_any) begin
            entry_reg[wr_ptr_reg] <= first_res;
        end
        if (push_two) begin
            entry_reg[wr_ptr_1] <= push.res_b;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_any |-> count_reg <= CNT_W'(DEPTH - 2))
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count out of range");

    a_last_closes_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        push_two |-> !push.res_a.last_of_item && push.res_b.last_of_item)
        else $error("last marker misplaced on a double close");

endmodule

`default_nettype wire

// ----- hdl/uvc_payload_frame_assembler.sv -----
// ----------------------------------------------------------------------------
// uvc_payload_frame_assembler: video payload header frame reassembly
// Tracks one stream of packet headers and reports each closed frame with
// its byte, packet and error counts, PTS, SCR, duration and interval.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Content
//   s_       in         s_valid / s_ready   packet descriptor and header bytes
//   m_       out        m_valid / m_ready   statistics of one closed frame
//   cfg_     in         cfg_wr_en           frames_enable, no read-back
//
// A request is registered, then processed when the result queue has two free
// entries; one request per cycle is sustained while m_ready stays high and the
// requests give no more than one result each on average. A request may give
// zero, one or two results, the first in the cycle after it is processed at the
// earliest; the queue drains one a cycle while m_ready is high.
// Synchronous active-low reset clears the frame state and sets frames_enable.
// A stall on m_ drops s_ready while a request waits with under two entries free.
// ----------------------------------------------------------------------------
`default_nettype none

module uvc_payload_frame_assembler #(
    parameter int FIFO_DEPTH = uvcfa_pkg::OUT_FIFO_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_timestamp_ns,
    input  wire logic        s_packet_error,
    input  wire logic [15:0] s_packet_length,
    input  wire logic [1:0]  s_header_room,
    input  wire logic [7:0]  s_header_length,
    input  wire logic [7:0]  s_header_flags,
    input  wire logic [31:0] s_pts_field,
    input  wire logic [31:0] s_stc_field,
    input  wire logic [15:0] s_sof_field,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_frame_bytes,
    output logic [31:0]      m_frame_packets,
    output logic [31:0]      m_frame_error_packets,
    output logic [31:0]      m_frame_duration,
    output logic [31:0]      m_frame_interval,
    output logic [31:0]      m_frame_pts,
    output logic [31:0]      m_frame_stc,
    output logic [15:0]      m_frame_sof,
    output logic             m_frame_errored,
    output logic             m_frame_eof,
    output logic             m_frame_fid,
    output logic             m_last_of_item
);
    import uvcfa_pkg::*;

    in_item_t in_item;
    push_t    push;
    logic     push_room;
    result_t  out_res;

    always_comb begin
        in_item.timestamp_ns  = s_timestamp_ns;
        in_item.packet_error  = s_packet_error;
        in_item.packet_length = s_packet_length;
        in_item.header_room   = s_header_room;
        in_item.header_length = s_header_length;
        in_item.header_flags  = s_header_flags;
        in_item.pts_field     = s_pts_field;
        in_item.stc_field     = s_stc_field;
        in_item.sof_field     = s_sof_field;
    end

    uvcfa_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_item     (in_item),
        .push_room   (push_room),
        .push        (push)
    );

    uvcfa_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (push_room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_frame_bytes         = out_res.frame_bytes;
    assign m_frame_packets       = out_res.frame_packets;
    assign m_frame_error_packets = out_res.frame_error_packets;
    assign m_frame_duration      = out_res.frame_duration;
    assign m_frame_interval      = out_res.frame_interval;
    assign m_frame_pts           = out_res.frame_pts;
    assign m_frame_stc           = out_res.frame_stc;
    assign m_frame_sof           = out_res.frame_sof;
    assign m_frame_errored       = out_res.frame_errored;
    assign m_frame_eof           = out_res.frame_eof;
    assign m_frame_fid           = out_res.frame_fid;
    assign m_last_of_item        = out_res.last_of_item;

endmodule

`default_nettype wire

// ----- bench/frame_check_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_check_pkg: frame statistics scoreboard for the payload frame assembler
// Keeps a private copy of the frame assembly state, works out the closed
// frames that every accepted request produces, and checks the results in order.
// ----------------------------------------------------------------------------
package frame_check_pkg;

    import uvcfa_pkg::*;

    localparam logic [1:0] ROOM_FULL      = 2'd2;
    localparam logic [1:0] ROOM_SPARE     = 2'd3;
    localparam logic [7:0] FLAGS_NONE     = 8'h00;
    localparam logic [7:0] RESERVED_FLAGS = 8'hB0;
    localparam int unsigned MAX_REPORTS   = 10;

    class frame_scoreboard;
        bit          enabled;
        bit [63:0]   start_time;
        bit [63:0]   last_close;
        bit [31:0]   byte_acc;
        bit [31:0]   packet_acc;
        bit [31:0]   error_packet_acc;
        bit [31:0]   pts_hold;
        bit [31:0]   stc_hold;
        bit [15:0]   sof_hold;
        bit          fid_now;
        bit          fid_valid;
        bit          error_flag;
        bit          frame_is_open;
        result_t     expected_frames[$];
        int unsigned failures;
        int unsigned reports;

        function new();
            enabled = 1'b1;
            failures = 0;
            reports = 0;
        endfunction

        function void set_enable(bit value);
            enabled = value;
        endfunction

        function int unsigned pending();
            return expected_frames.size();
        endfunction

        function void start_frame(bit fid, bit [63:0] now);
            frame_is_open = 1'b1;
            fid_valid = 1'b1;
            fid_now = fid;
            start_time = now;
        endfunction

        // Reports and clears the open frame, noting its close time; FID tracking stays.
        function result_t close_frame(bit by_eof, bit [63:0] now);
            result_t   frame;
            bit [63:0] since_start;
            bit [63:0] since_close;
            since_start = now - start_time;
            since_close = now - last_close;
            frame.frame_bytes = byte_acc;
            frame.frame_packets = packet_acc;
            frame.frame_error_packets = error_packet_acc;
            frame.frame_duration = since_start[31:0];
            frame.frame_interval = (last_close != 64'd0) ? since_close[31:0] : 32'd0;
            frame.frame_pts = pts_hold;
            frame.frame_stc = stc_hold;
            frame.frame_sof = sof_hold;
            frame.frame_errored = !by_eof || error_flag;
            frame.frame_eof = by_eof;
            frame.frame_fid = fid_now;
            frame.last_of_item = 1'b0;
            last_close = now;
            byte_acc = '0;
            packet_acc = '0;
            error_packet_acc = '0;
            pts_hold = '0;
            stc_hold = '0;
            sof_hold = '0;
            error_flag = 1'b0;
            frame_is_open = 1'b0;
            return frame;
        endfunction

        function void note_packet(in_item_t req);
            result_t   toggled;
            result_t   at_eof;
            bit        have_toggled;
            bit        have_eof;
            bit [31:0] pts;
            bit [31:0] stc;
            bit [15:0] sof;
            bit        fid;
            bit        pts_flag;
            bit        scr_flag;
            if (!enabled)
                return;
            // A descriptor error counts even when the header is unusable.
            if (req.packet_error) begin
                error_flag = 1'b1;
                error_packet_acc++;
            end
            if (req.packet_length == 16'd0 || req.header_room == ROOM_NONE)
                return;
            pts = req.pts_field;
            stc = req.stc_field;
            sof = req.sof_field;
            if (req.header_room == ROOM_FLAGS) begin
                pts = '0;
                stc = '0;
                sof = '0;
            end
            if (req.header_length < HDR_MIN_LEN || req.header_length > req.packet_length)
                return;

            have_toggled = 1'b0;
            have_eof = 1'b0;
            fid = (req.header_flags & FLAG_FID) != FLAGS_NONE;
            if (!frame_is_open) begin
                start_frame(fid, req.timestamp_ns);
            end else if (fid_valid && fid != fid_now) begin
                toggled = close_frame(1'b0, req.timestamp_ns);
                have_toggled = 1'b1;
                start_frame(fid, req.timestamp_ns);
            end

            byte_acc += 32'(req.packet_length) - 32'(req.header_length);
            packet_acc++;
            if ((req.header_flags & FLAG_ERR) != FLAGS_NONE)
                error_flag = 1'b1;
            pts_flag = (req.header_flags & FLAG_PTS) != FLAGS_NONE;
            scr_flag = (req.header_flags & FLAG_SCR) != FLAGS_NONE;
            if (pts_flag && req.header_length >= PTS_HDR_LEN)
                pts_hold = pts;
            if (pts_flag && scr_flag && req.header_length >= FULL_HDR_LEN) begin
                stc_hold = stc;
                sof_hold = sof;
            end
            if ((req.header_flags & FLAG_EOF) != FLAGS_NONE) begin
                at_eof = close_frame(1'b1, req.timestamp_ns);
                have_eof = 1'b1;
            end

            if (have_toggled) begin
                toggled.last_of_item = !have_eof;
                expected_frames.push_back(toggled);
            end
            if (have_eof) begin
                at_eof.last_of_item = 1'b1;
                expected_frames.push_back(at_eof);
            end
        endfunction

        function void check_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
            if (got_val !== exp_val) begin
                failures++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: %s mismatch: expected %0h, actual %0h",
                             $time, name, exp_val, got_val);
                end
            end
        endfunction

        function void check_frame(result_t got);
            result_t want;
            if (expected_frames.size() == 0) begin
                failures++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: frame result with none expected: bytes %0h packets %0h",
                             $time, got.frame_bytes, got.frame_packets);
                end
                return;
            end
            want = expected_frames.pop_front();
            check_field("frame_bytes", 64'(want.frame_bytes), 64'(got.frame_bytes));
            check_field("frame_packets", 64'(want.frame_packets), 64'(got.frame_packets));
            check_field("frame_error_packets", 64'(want.frame_error_packets),
                        64'(got.frame_error_packets));
            check_field("frame_duration", 64'(want.frame_duration),
                        64'(got.frame_duration));
            check_field("frame_interval", 64'(want.frame_interval),
                        64'(got.frame_interval));
            check_field("frame_pts", 64'(want.frame_pts), 64'(got.frame_pts));
            check_field("frame_stc", 64'(want.frame_stc), 64'(got.frame_stc));
            check_field("frame_sof", 64'(want.frame_sof), 64'(got.frame_sof));
            check_field("frame_errored", 64'(want.frame_errored), 64'(got.frame_errored));
            check_field("frame_eof", 64'(want.frame_eof), 64'(got.frame_eof));
            check_field("frame_fid", 64'(want.frame_fid), 64'(got.frame_fid));
            check_field("last_of_item", 64'(want.last_of_item), 64'(got.last_of_item));
        endfunction
    endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the video payload frame assembler
// Sends directed and randomized packet header streams under several idle and
// stall patterns, toggles frame reconstruction on and off while idle, and
// checks every closed frame against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import uvcfa_pkg::*;
    import frame_check_pkg::*;

    localparam int DRAIN_CYCLES     = 16;
    localparam int RANDOM_PER_PHASE = 360;
    localparam int IGNORED_ITEMS    = 12;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    req_bus = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_frame_bytes;
    logic [31:0] m_frame_packets;
    logic [31:0] m_frame_error_packets;
    logic [31:0] m_frame_duration;
    logic [31:0] m_frame_interval;
    logic [31:0] m_frame_pts;
    logic [31:0] m_frame_stc;
    logic [15:0] m_frame_sof;
    logic        m_frame_errored;
    logic        m_frame_eof;
    logic        m_frame_fid;
    logic        m_last_of_item;
    result_t     seen_frame;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // Packet stream generator state.
    bit [63:0]   stream_time = 64'd5000;
    bit          stream_fid = 1'b0;
    int unsigned packets_left = 0;

    frame_scoreboard frame_sb;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    uvc_payload_frame_assembler dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_wr_data           (cfg_wr_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_timestamp_ns        (req_bus.timestamp_ns),
        .s_packet_error        (req_bus.packet_error),
        .s_packet_length       (req_bus.packet_length),
        .s_header_room         (req_bus.header_room),
        .s_header_length       (req_bus.header_length),
        .s_header_flags        (req_bus.header_flags),
        .s_pts_field           (req_bus.pts_field),
        .s_stc_field           (req_bus.stc_field),
        .s_sof_field           (req_bus.sof_field),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_frame_bytes         (m_frame_bytes),
        .m_frame_packets       (m_frame_packets),
        .m_frame_error_packets (m_frame_error_packets),
        .m_frame_duration      (m_frame_duration),
        .m_frame_interval      (m_frame_interval),
        .m_frame_pts           (m_frame_pts),
        .m_frame_stc           (m_frame_stc),
        .m_frame_sof           (m_frame_sof),
        .m_frame_errored       (m_frame_errored),
        .m_frame_eof           (m_frame_eof),
        .m_frame_fid           (m_frame_fid),
        .m_last_of_item        (m_last_of_item)
    );

    assign seen_frame = {m_frame_bytes, m_frame_packets, m_frame_error_packets,
                         m_frame_duration, m_frame_interval, m_frame_pts, m_frame_stc,
                         m_frame_sof, m_frame_errored, m_frame_eof, m_frame_fid,
                         m_last_of_item};

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Results are checked before the request of the same edge is noted; a
    // request can never produce a result at the edge that accepts it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                frame_sb.set_enable(cfg_wr_data);
            if (m_valid && m_ready)
                frame_sb.check_frame(seen_frame);
            if (s_valid && s_ready)
                frame_sb.note_packet(req_bus);
        end
    end

    function automatic in_item_t make_request(bit [63:0] ts, bit perr, bit [15:0] plen,
                                              bit [1:0] room, bit [7:0] hlen,
                                              bit [7:0] flags, bit [31:0] pts,
                                              bit [31:0] stc, bit [15:0] sof);
        in_item_t req;
        req = {ts, perr, plen, room, hlen, flags, pts, stc, sof};
        return req;
    endfunction

    // Mostly well-formed frames with random content; the rest is noise.
    function automatic in_item_t next_stream_request();
        in_item_t    req;
        bit [7:0]    flags;
        int unsigned pick;
        if ($urandom_range(99) < 12) begin
            req.timestamp_ns = {$urandom, $urandom};
            req.packet_error = 1'($urandom_range(1));
            req.packet_length = $urandom_range(1) ? 16'($urandom_range(65535))
                                                  : 16'($urandom_range(16));
            req.header_room = 2'($urandom_range(3));
            req.header_length = 8'($urandom);
            req.header_flags = 8'($urandom);
            req.pts_field = $urandom;
            req.stc_field = $urandom;
            req.sof_field = 16'($urandom);
            return req;
        end
        if (packets_left == 0) begin
            packets_left = ($urandom_range(4) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(1, 6);
            if ($urandom_range(5) != 0)
                stream_fid = !stream_fid;
        end
        if ($urandom_range(49) == 0)
            stream_time = {$urandom, $urandom};
        else
            stream_time += 64'($urandom_range(1, 130000));
        req.timestamp_ns = stream_time;
        req.packet_error = ($urandom_range(24) == 0);
        pick = $urandom_range(9);
        req.header_room = (pick == 0) ? ROOM_FLAGS : (pick == 1) ? ROOM_SPARE : ROOM_FULL;
        pick = $urandom_range(9);
        req.header_length = (pick < 6) ? FULL_HDR_LEN :
                            (pick < 8) ? HDR_MIN_LEN : 8'($urandom_range(HDR_MIN_LEN, 255));
        req.packet_length = 16'(req.header_length) + 16'($urandom_range(3072));
        if ($urandom_range(15) == 0)
            req.packet_length = 16'($urandom_range(req.header_length, 65535));
        flags = stream_fid ? FLAG_FID : FLAGS_NONE;
        if ($urandom_range(1))
            flags |= FLAG_PTS;
        if ($urandom_range(1))
            flags |= FLAG_SCR;
        if ($urandom_range(19) == 0)
            flags |= FLAG_ERR;
        if ($urandom_range(9) == 0)
            flags |= RESERVED_FLAGS & 8'($urandom);
        packets_left--;
        if (packets_left == 0 && $urandom_range(5) != 0)
            flags |= FLAG_EOF;
        req.header_flags = flags;
        req.pts_field = $urandom;
        req.stc_field = $urandom;
        req.sof_field = 16'($urandom);
        return req;
    endfunction

    task automatic send_request(input in_item_t req);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        req_bus <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // A request that closes no frame may still be inside the block when the
    // last expected frame arrives, so a further drain wait follows.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (frame_sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES)
            @(posedge aclk);
    endtask

    task automatic write_enable(input bit value);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_stream(input int count);
        repeat (count)
            send_request(next_stream_request());
    endtask

    initial begin
        #1_000_000;
        $display("** uvc_payload_frame_assembler: FAILED **");
        $finish;
    end

    initial begin
        frame_sb = new();
        repeat (3)
            @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_enable(1'b1);

        // Frame opened and closed at time zero, so the next close has no interval.
        send_request(make_request(64'd0, 1'b0, 16'd100, ROOM_FULL, FULL_HDR_LEN,
                                  FLAG_PTS | FLAG_SCR, '1, '1, '1));
        send_request(make_request(64'd0, 1'b0, 16'd50, ROOM_FULL, FULL_HDR_LEN,
                                  FLAG_EOF, '0, '0, '0));
        // Unusable packets: empty, no header room, header too short or too long.
        send_request(make_request(64'd1000, 1'b1, 16'd0, ROOM_FULL, FULL_HDR_LEN,
                                  FLAG_EOF, '0, '0, '0));
        send_request(make_request(64'd1100, 1'b1, 16'd10, ROOM_NONE, FULL_HDR_LEN,
                                  FLAG_EOF, '0, '0, '0));
        send_request(make_request(64'd1200, 1'b0, 16'd10, ROOM_FULL, 8'd1,
                                  FLAG_EOF, '0, '0, '0));
        send_request(make_request(64'd1300, 1'b0, 16'd10, ROOM_FULL, 8'd20,
                                  FLAG_EOF, '0, '0, '0));
        send_request(make_request(64'd1400, 1'b0, 16'd6, ROOM_FLAGS, PTS_HDR_LEN,
                                  FLAG_FID | FLAG_PTS, 32'h1234_5678, 32'h9ABC_DEF0,
                                  16'h1357));
        send_request(make_request(64'd1500, 1'b0, 16'hFFFF, ROOM_SPARE, FULL_HDR_LEN,
                                  FLAG_FID | FLAG_PTS | FLAG_SCR, 32'hA5A5_5A5A,
                                  32'h0F0F_F0F0, 16'hC33C));
        send_request(make_request(64'd1600, 1'b0, 16'd2, ROOM_FULL, HDR_MIN_LEN,
                                  FLAG_ERR, '0, '0, '0));
        // FID change and EOF in one packet close two frames.
        send_request(make_request(64'd1700, 1'b0, 16'hFFFF, ROOM_FULL, 8'hFF,
                                  FLAG_FID | FLAG_EOF, '1, '0, '1));
        send_request(make_request('1, 1'b1, 16'd12, ROOM_FULL, FULL_HDR_LEN,
                                  8'hFF, '1, '1, '1));
        send_request(make_request(64'd2000, 1'b0, 16'd40, ROOM_FULL, FULL_HDR_LEN,
                                  FLAG_SCR, 32'h1111_1111, 32'h2222_2222, 16'h3333));
        send_request(make_request(64'd2100, 1'b0, 16'd40, ROOM_FULL, 8'd5,
                                  FLAG_PTS, 32'h4444_4444, '0, '0));
        send_request(make_request(64'd2200, 1'b0, 16'd40, ROOM_FULL, 8'd8,
                                  FLAG_PTS | FLAG_SCR, 32'h5555_5555, 32'h6666_6666,
                                  16'h7777));
        send_request(make_request(64'd2300, 1'b0, 16'd40, ROOM_FULL, FULL_HDR_LEN,
                                  FLAG_PTS | FLAG_SCR | FLAG_EOF, 32'h8888_8888,
                                  32'h9999_9999, 16'hAAAA));
        send_request(make_request(64'd2400, 1'b0, 16'd2, ROOM_FULL, HDR_MIN_LEN,
                                  RESERVED_FLAGS, '0, '0, '0));
        send_request(make_request(64'd2500, 1'b0, 16'd12, ROOM_SPARE, 8'd0,
                                  FLAG_FID, '0, '0, '0));
        send_request(make_request(64'd2600, 1'b1, 16'd12, ROOM_FLAGS, FULL_HDR_LEN,
                                  FLAG_PTS | FLAG_SCR, '1, '1, '1));
        send_request(make_request(64'h8000_0000_0000_0000, 1'b0, 16'd300, ROOM_FULL,
                                  FULL_HDR_LEN, FLAG_FID | FLAG_EOF, '0, '0, '0));
        send_request(make_request(64'h8000_0000_0000_0100, 1'b0, 16'hFFFF, ROOM_FULL,
                                  HDR_MIN_LEN, FLAGS_NONE, '0, '0, '0));
        send_request(make_request(64'h8000_0000_0000_0200, 1'b1, 16'hFFFF, ROOM_FULL,
                                  HDR_MIN_LEN, FLAG_EOF, '0, '0, '0));

        write_enable(1'b0);
        send_stream(IGNORED_ITEMS);
        write_enable(1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 73;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 73;
                end
                default: begin
                    send_idle_pct = 36;
                    recv_stall_pct = 36;
                end
            endcase
            send_stream(RANDOM_PER_PHASE);
            // Switch reconstruction off and back on with a frame possibly open.
            if (phase == 1) begin
                write_enable(1'b0);
                send_stream(IGNORED_ITEMS);
                write_enable(1'b1);
            end
        end

        wait_idle();
        if (frame_sb.failures == 0 && frame_sb.pending() == 0)
            $display("** uvc_payload_frame_assembler: PASSED **");
        else
            $display("** uvc_payload_frame_assembler: FAILED **");
        $finish;
    end

endmodule
